// ----- hdl/wto_pkg.sv -----
// Shared constants and types for the wavetable oscillator.
`timescale 1ns / 1ps
package wto_pkg;

  // Fixed field widths
  localparam int FREQ_W = 16;
  localparam int RATE_W = 18;
  localparam int WAVE_W = 2;
  localparam int FRAC_W = 16;

  // Default sizing, handed to the top-level parameters
  localparam int TABLE_SIZE_DEF  = 8192;
  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;

  // Register map
  localparam logic REG_WAVE_TYPE   = 1'b0;
  localparam logic REG_SAMPLE_RATE = 1'b1;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(48000);

  // Waveform codes
  localparam logic [WAVE_W-1:0] WAVE_NONE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd3;

  // Sine ROM build: pi in Q30 and Taylor term divisors (2n)(2n+1)
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint unsigned TERM_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156, 64'd210, 64'd272};

  // Request from the sequencer to the increment divider
  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] freq;
    logic [RATE_W-1:0] rate;
  } div_req_t;

endpackage

// ----- hdl/wto_front.sv -----
// Input side: takes frequency words into a two-entry queue.
`timescale 1ns / 1ps
module wto_front
  import wto_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FREQ_W-1:0] in_freq,
  output logic              q_valid,
  output logic [FREQ_W-1:0] q_freq,
  input  logic              q_pop
);

  logic [FREQ_W-1:0] slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != 2'd0);
  assign q_freq   = slot[rd_ptr];

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= in_freq;
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0)
    else $error("queue popped while empty");

endmodule

// ----- hdl/wto_div.sv -----
// Serial divider for the phase increment, one quotient bit per cycle.
`timescale 1ns / 1ps
module wto_div
  import wto_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  div_req_t              req,
  output logic                  done,
  output logic [PHASE_BITS-1:0] quotient
);

  localparam int CNT_W = $clog2(PHASE_BITS);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic [RATE_W-1:0]     rem;
  logic [RATE_W-1:0]     divisor;
  logic [PHASE_BITS-1:0] quo;
  logic                  too_fast;
  logic [RATE_W:0]       rem2;
  logic                  fits;

  // Trial subtract of one step
  assign rem2 = {rem, 1'b0};
  assign fits = (rem2 >= {1'b0, divisor});

  // freq >= rate means one full cycle or more (also rate 0): no advance
  assign quotient = too_fast ? '0 : quo;

  // Control: done stays high with the quotient until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(PHASE_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder starts at freq, zeros shift in below it
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= RATE_W'(req.freq);
      divisor  <= req.rate;
      quo      <= '0;
      too_fast <= ({2'b00, req.freq} >= req.rate);
    end else if (busy) begin
      if (fits) rem <= RATE_W'(rem2 - {1'b0, divisor});
      else      rem <= rem2[RATE_W-1:0];
      quo <= {quo[PHASE_BITS-2:0], fits};
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider restarted while busy");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    $rose(done) |-> !busy && $past(busy))
    else $error("divider done without a finished run");

endmodule

// ----- hdl/wto_back.sv -----
// Back end: phase accumulator, wavetable lookup, interpolation and output word.
`timescale 1ns / 1ps
module wto_back
  import wto_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [WAVE_W-1:0]      wave_type,
  input  logic [RATE_W-1:0]      sample_rate,
  input  logic                   q_valid,
  input  logic [FREQ_W-1:0]      q_freq,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_sample
);

  localparam int TB    = $clog2(TABLE_SIZE);
  localparam int RB    = PHASE_BITS - TB;
  localparam int QSIZE = TABLE_SIZE / 4;
  localparam int KW    = TB - 1;
  localparam int EW    = SAMPLE_BITS + 1;
  localparam int DW    = SAMPLE_BITS + 2;
  localparam int PW    = SAMPLE_BITS + 19;
  localparam int YW    = PW - FRAC_W + 1;
  localparam int SH    = 30 - (SAMPLE_BITS - 1);
  localparam longint unsigned QUAD2 = 2 * QSIZE;
  localparam longint unsigned ROUND = 64'd1 << (SH - 1);
  localparam logic signed [EW-1:0] FS = EW'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [YW-1:0] Y_MAX = YW'(FS) - YW'(1);
  localparam logic signed [YW-1:0] Y_MIN = -YW'(FS);

  typedef logic [SAMPLE_BITS-1:0] rom_t [QSIZE+1];
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_OUT, S_DIV} state_t;

  // Quarter-wave sine, Q30 Taylor series rounded to the sample scale
  function automatic rom_t build_sine();
    rom_t            tbl;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    for (int k = 0; k <= QSIZE; k++) begin
      x  = (PI_Q30 * longint'(k)) / QUAD2;
      x2 = (x * x) >> 30;
      t  = x;
      s  = longint'(x);
      for (int n = 0; n < 8; n++) begin
        t = ((t * x2) >> 30) / TERM_DIV[n];
        if (n[0] == 1'b0) s = s - longint'(t);
        else              s = s + longint'(t);
      end
      if (s < 0) s = 0;
      tbl[k] = SAMPLE_BITS'(($unsigned(s) + ROUND) >> SH);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_sine();

  state_t                   state;
  logic                     hold;
  logic [PHASE_BITS-1:0]    phase;
  div_req_t                 div_req;
  logic                     div_done;
  logic [PHASE_BITS-1:0]    div_quo;

  logic [TB-1:0]            idx_a;
  logic [TB-1:0]            idx_b;
  logic [FRAC_W-1:0]        frac;
  logic [RB+FRAC_W-1:0]     frac_ext;
  logic [KW-1:0]            k_a;
  logic [KW-1:0]            k_b;
  logic [SAMPLE_BITS-1:0]   rom_a;
  logic [SAMPLE_BITS-1:0]   rom_b;
  logic signed [EW-1:0]     ent_a;
  logic signed [EW-1:0]     ent_b;
  logic signed [EW-1:0]     a_r;
  logic signed [DW-1:0]     diff_r;
  logic signed [PW-1:0]     prod_r;
  logic signed [PW-1:0]     prod_rnd;
  logic signed [YW-1:0]     y;
  logic [SAMPLE_BITS-1:0]   y_sat;
  logic                     load;

  wto_div #(.PHASE_BITS(PHASE_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Index and fraction from the current phase
  assign idx_a    = phase[PHASE_BITS-1 -: TB];
  assign idx_b    = idx_a + TB'(1);
  assign frac_ext = {phase[RB-1:0], {FRAC_W{1'b0}}};
  assign frac     = frac_ext[RB+FRAC_W-1 -: FRAC_W];

  // Quarter-wave folding of each index
  function automatic logic [KW-1:0] fold(input logic [TB-1:0] i);
    logic [KW-1:0] r;
    r = {1'b0, i[TB-3:0]};
    return i[TB-2] ? (KW'(QSIZE) - r) : r;
  endfunction

  assign k_a = fold(idx_a);
  assign k_b = fold(idx_b);

  // Sine ROM, two registered read ports
  always_ff @(posedge clk) begin
    rom_a <= SINE_ROM[k_a];
    rom_b <= SINE_ROM[k_b];
  end

  // Table entry for the selected waveform
  function automatic logic signed [EW-1:0] entry(input logic [WAVE_W-1:0] wt,
                                                 input logic [TB-1:0] i,
                                                 input logic [SAMPLE_BITS-1:0] rom);
    logic [TB+SAMPLE_BITS-1:0]  sw;
    logic signed [EW-1:0]       v;
    sw = {i, {SAMPLE_BITS{1'b0}}} >> TB;
    case (wt)
      WAVE_SINE:   v = i[TB-1] ? -$signed({1'b0, rom}) : $signed({1'b0, rom});
      WAVE_SAW:    v = $signed({1'b0, sw[SAMPLE_BITS-1:0]}) - FS;
      WAVE_SQUARE: v = i[TB-1] ? FS : -FS;
      default:     v = '0;
    endcase
    return v;
  endfunction

  assign ent_a = entry(wave_type, idx_a, rom_a);
  assign ent_b = entry(wave_type, idx_b, rom_b);

  // Round the product, add the base entry, saturate
  assign prod_rnd = prod_r + PW'(32768);
  assign y        = YW'(a_r) + YW'(prod_rnd >>> FRAC_W);
  always_comb begin
    if (y > Y_MAX)      y_sat = Y_MAX[SAMPLE_BITS-1:0];
    else if (y < Y_MIN) y_sat = Y_MIN[SAMPLE_BITS-1:0];
    else                y_sat = y[SAMPLE_BITS-1:0];
  end

  assign q_pop         = (state == S_IDLE) && q_valid;
  assign load          = (state == S_OUT) && (!out_valid || out_ready);
  assign div_req.start = q_pop && (wave_type != WAVE_NONE);
  assign div_req.freq  = q_freq;
  assign div_req.rate  = sample_rate;

  // Sequencer, phase and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hold      <= 1'b0;
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            hold  <= (wave_type == WAVE_NONE);
            state <= (wave_type == WAVE_NONE) ? S_OUT : S_READ;
          end
        end
        S_READ:  state <= S_MUL;
        S_MUL:   state <= S_OUT;
        S_OUT: begin
          if (load) begin
            state <= hold ? S_IDLE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            phase <= phase + div_quo;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Interpolation datapath
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      a_r    <= ent_a;
      diff_r <= DW'(ent_b) - DW'(ent_a);
    end
    if (state == S_MUL) prod_r <= diff_r * $signed({1'b0, frac});
    if (load) out_sample <= hold ? '0 : y_sat;
  end

  a_phase_only_at_end: assert property (@(posedge clk) disable iff (rst)
    phase != $past(phase) |-> $past(state == S_DIV && div_done))
    else $error("phase moved outside the update step");

  a_none_no_divide: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> wave_type != WAVE_NONE && state == S_IDLE)
    else $error("divider started for a silent tick");

endmodule

// ----- hdl/wavetable_oscillator_top.sv -----
// Top level of the wavetable oscillator: stream ports and configuration registers.
//
// Each input word is one sample tick carrying a frequency in whole Hz; for each
// one the block returns one signed Q1.15 sample read at the current phase with
// linear interpolation between table entries, then advances a 32-bit phase by
// floor(freq * 2^32 / sample_rate_hz) (no advance when freq >= sample rate).
// A tick is finished, phase update included, before the next word leaves the
// queue; the serial divider forms the increment one quotient bit per cycle.
// With wave_type none a tick yields 0 and leaves the phase alone. Input words
// queue two deep and the result sits in an output register, so either side
// may stall. Write configuration only while idle: register 0 is wave_type
// (0 none, 1 sine, 2 saw, 3 square), register 1 is sample_rate_hz.
// cfg_ready is always high.
`timescale 1ns / 1ps
module wavetable_oscillator_top
  import wto_pkg::*;
#(
  parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
  parameter int PHASE_BITS  = PHASE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [FREQ_W-1:0] s_axis_tdata,   // [15:0] frequency_hz
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
  // configuration writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_addr,
  input  logic [RATE_W-1:0] cfg_data
);

  logic [WAVE_W-1:0]      wave_type;
  logic [RATE_W-1:0]      sample_rate;
  logic                   q_valid;
  logic [FREQ_W-1:0]      q_freq;
  logic                   q_pop;
  logic [SAMPLE_BITS-1:0] sample;

  assign cfg_ready    = 1'b1;
  assign m_axis_tdata = OUT_W'(sample);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type   <= WAVE_NONE;
      sample_rate <= RATE_RESET;
    end else if (cfg_valid) begin
      case (cfg_addr)
        REG_WAVE_TYPE:   wave_type   <= cfg_data[WAVE_W-1:0];
        REG_SAMPLE_RATE: sample_rate <= cfg_data;
        default:         wave_type   <= wave_type;
      endcase
    end
  end

  wto_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_freq  (s_axis_tdata),
    .q_valid  (q_valid),
    .q_freq   (q_freq),
    .q_pop    (q_pop)
  );

  wto_back #(
    .TABLE_SIZE  (TABLE_SIZE),
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .wave_type   (wave_type),
    .sample_rate (sample_rate),
    .q_valid     (q_valid),
    .q_freq      (q_freq),
    .q_pop       (q_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_sample  (sample)
  );

endmodule
